// ===== design/mlfq_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared constants, command codes and control structs for the scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

	localparam int MAX_THREADS_DEF = 16;
	localparam int NUM_LEVELS_DEF  = 4;

	localparam int OP_W    = 3;
	localparam int ID_W    = 4;
	localparam int EL_W    = 16;
	localparam int RSN_W   = 2;
	localparam int STS_W   = 2;
	localparam int SLICE_W = 12;
	localparam int CFG_W   = 10;
	localparam int CIDX_W  = 1;

	localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
	localparam logic [OP_W-1:0] OP_SWITCH = 3'd1;
	localparam logic [OP_W-1:0] OP_EXIT   = 3'd2;
	localparam logic [OP_W-1:0] OP_BLOCK  = 3'd3;
	localparam logic [OP_W-1:0] OP_READY  = 3'd4;
	localparam logic [OP_W-1:0] OP_BOOST  = 3'd5;

	localparam logic [1:0] TS_READY   = 2'd0;
	localparam logic [1:0] TS_RUNNING = 2'd1;
	localparam logic [1:0] TS_BLOCKED = 2'd2;

	localparam logic [RSN_W-1:0] RSN_BLOCKED = 2'd2;

	localparam logic [STS_W-1:0] STS_OK   = 2'd0;
	localparam logic [STS_W-1:0] STS_NONE = 2'd1;
	localparam logic [STS_W-1:0] STS_BAD  = 2'd2;

	localparam logic [CIDX_W-1:0] CFG_BASE = 1'd0;
	localparam logic [CIDX_W-1:0] CFG_STEP = 1'd1;

	localparam logic [CFG_W-1:0] BASE_RST = 10'd5;
	localparam logic [CFG_W-1:0] STEP_RST = 10'd5;

	localparam logic [SLICE_W-1:0] SLICE_MAX = 12'd4095;

	localparam int CMD_W = 4;
	localparam logic [CMD_W-1:0] C_NOP    = 4'd0;
	localparam logic [CMD_W-1:0] C_LATCH  = 4'd1;
	localparam logic [CMD_W-1:0] C_CREATE = 4'd2;
	localparam logic [CMD_W-1:0] C_BLOCK  = 4'd3;
	localparam logic [CMD_W-1:0] C_READY  = 4'd4;
	localparam logic [CMD_W-1:0] C_EXIT   = 4'd5;
	localparam logic [CMD_W-1:0] C_CHARGE = 4'd6;
	localparam logic [CMD_W-1:0] C_DEMOTE = 4'd7;
	localparam logic [CMD_W-1:0] C_PUSH   = 4'd8;
	localparam logic [CMD_W-1:0] C_SCAN   = 4'd9;
	localparam logic [CMD_W-1:0] C_SELECT = 4'd10;
	localparam logic [CMD_W-1:0] C_ROTATE = 4'd11;
	localparam logic [CMD_W-1:0] C_BOOST  = 4'd12;
	localparam logic [CMD_W-1:0] C_BCLR   = 4'd13;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
	} ctl_t;

	typedef struct packed {
		logic run_v;
		logic scan_last;
		logic none_found;
		logic head_blk;
		logic boost_last;
	} sts_t;

	// base + lvl * step, saturated
	function automatic logic [SLICE_W-1:0] level_slice(input logic [CFG_W-1:0] base,
		input logic [CFG_W-1:0] step, input logic [3:0] lvl);
		logic [14:0] s;
		s = 15'(base) + 15'(lvl) * 15'(step);
		if (s > 15'(SLICE_MAX))
			return SLICE_MAX;
		return s[SLICE_W-1:0];
	endfunction

endpackage

// ===== design/mlfq_dp.sv =====
// ----------------------------------------------------------------------------
// mlfq_dp
// Thread table, level FIFOs, scan flags and result registers.
// ----------------------------------------------------------------------------
module mlfq_dp #(
	parameter int MAX_THREADS = mlfq_pkg::MAX_THREADS_DEF,
	parameter int NUM_LEVELS  = mlfq_pkg::NUM_LEVELS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mlfq_pkg::ctl_t                   ctl,
	output mlfq_pkg::sts_t                   sts,
	input  logic [mlfq_pkg::ID_W-1:0]        thread_id,
	input  logic [mlfq_pkg::EL_W-1:0]        elapsed_ms,
	input  logic [mlfq_pkg::RSN_W-1:0]       leave_reason,
	input  logic                             cfg_we,
	input  logic [mlfq_pkg::CIDX_W-1:0]      cfg_index,
	input  logic [mlfq_pkg::CFG_W-1:0]       cfg_data,
	output logic [mlfq_pkg::STS_W-1:0]       status,
	output logic [mlfq_pkg::ID_W-1:0]        next_thread,
	output logic [mlfq_pkg::SLICE_W-1:0]     slice_ms
);
	localparam int TW = $clog2(MAX_THREADS);
	localparam int LW = $clog2(NUM_LEVELS);

	logic              used_q [MAX_THREADS];
	logic [1:0]        stat_q [MAX_THREADS];
	logic [LW-1:0]     lvl_q  [MAX_THREADS];
	logic [15:0]       time_q [MAX_THREADS];
	logic [TW-1:0]     link_q [MAX_THREADS];
	logic [TW-1:0]     head_q [NUM_LEVELS];
	logic [TW-1:0]     tail_q [NUM_LEVELS];
	logic              lval_q [NUM_LEVELS];
	logic              flag_q [NUM_LEVELS];
	logic [TW-1:0]     run_q;
	logic              run_v_q;
	logic [mlfq_pkg::ID_W-1:0]  id_q;
	logic [mlfq_pkg::EL_W-1:0]  el_q;
	logic [mlfq_pkg::RSN_W-1:0] rsn_q;
	logic [mlfq_pkg::CFG_W-1:0] base_q, step_q;
	logic [TW-1:0]     scan_q;
	logic [LW-1:0]     sel_q;
	logic [LW-1:0]     bl_q;
	logic [16:0]       sum_q;
	logic [mlfq_pkg::STS_W-1:0]   res_sts_q;
	logic [mlfq_pkg::ID_W-1:0]    res_nxt_q;
	logic [mlfq_pkg::SLICE_W-1:0] res_slc_q;

	logic [TW-1:0] idx;
	logic          id_ok;
	logic [TW-1:0] hd;
	logic [LW-1:0] rl;
	logic [LW-1:0] fnd;
	logic          any;
	logic [15:0]   sat;
	logic [7:0]    hd8;

	assign idx   = TW'(id_q);
	assign id_ok = 32'(id_q) < MAX_THREADS;
	assign hd    = head_q[sel_q];
	assign hd8   = 8'(hd);
	assign rl    = lvl_q[run_q];
	assign sat   = sum_q[16] ? 16'hFFFF : sum_q[15:0];

	always_comb begin
		fnd = '0;
		any = 1'b0;
		for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
			if (flag_q[l]) begin
				fnd = LW'(l);
				any = 1'b1;
			end
		end
	end

	assign sts.run_v      = run_v_q;
	assign sts.scan_last  = scan_q == TW'(MAX_THREADS - 1);
	assign sts.none_found = !any;
	assign sts.head_blk   = stat_q[hd] == mlfq_pkg::TS_BLOCKED;
	assign sts.boost_last = bl_q == LW'(NUM_LEVELS - 1);

	assign status      = res_sts_q;
	assign next_thread = res_nxt_q;
	assign slice_ms    = res_slc_q;

	// link store: undefined until written, no reset
	always_ff @(posedge clk) begin
		unique case (ctl.cmd)
			mlfq_pkg::C_CREATE: begin
				if (id_ok && !used_q[idx]) begin
					if (lval_q[0])
						link_q[tail_q[0]] <= idx;
					link_q[idx] <= idx;
				end
			end
			mlfq_pkg::C_PUSH: begin
				if (lval_q[rl])
					link_q[tail_q[rl]] <= run_q;
				link_q[run_q] <= run_q;
			end
			mlfq_pkg::C_ROTATE: begin
				if (stat_q[hd] == mlfq_pkg::TS_BLOCKED && hd != tail_q[sel_q]) begin
					link_q[tail_q[sel_q]] <= hd;
					link_q[hd] <= hd;
				end
			end
			mlfq_pkg::C_BOOST: begin
				if (lval_q[bl_q] && lval_q[0])
					link_q[tail_q[0]] <= head_q[bl_q];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.cmd == mlfq_pkg::C_LATCH) begin
			id_q  <= thread_id;
			el_q  <= elapsed_ms;
			rsn_q <= leave_reason;
		end
		if (ctl.cmd == mlfq_pkg::C_CHARGE)
			sum_q <= 17'(time_q[run_q]) + 17'(el_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_THREADS; i++) begin
				used_q[i] <= 1'b0;
				stat_q[i] <= mlfq_pkg::TS_READY;
				lvl_q[i]  <= '0;
				time_q[i] <= '0;
			end
			for (int l = 0; l < NUM_LEVELS; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= '0;
				lval_q[l] <= 1'b0;
				flag_q[l] <= 1'b0;
			end
			run_q     <= '0;
			run_v_q   <= 1'b0;
			scan_q    <= '0;
			sel_q     <= '0;
			bl_q      <= '0;
			base_q    <= mlfq_pkg::BASE_RST;
			step_q    <= mlfq_pkg::STEP_RST;
			res_sts_q <= mlfq_pkg::STS_OK;
			res_nxt_q <= '0;
			res_slc_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					mlfq_pkg::CFG_BASE: base_q <= cfg_data;
					mlfq_pkg::CFG_STEP: step_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (ctl.cmd)
				mlfq_pkg::C_LATCH: begin
					res_sts_q <= mlfq_pkg::STS_OK;
					res_nxt_q <= '0;
					res_slc_q <= '0;
					scan_q    <= '0;
					bl_q      <= LW'(1);
					for (int l = 0; l < NUM_LEVELS; l++)
						flag_q[l] <= 1'b0;
				end
				mlfq_pkg::C_CREATE: begin
					if (!id_ok || used_q[idx]) begin
						res_sts_q <= mlfq_pkg::STS_BAD;
					end else begin
						used_q[idx] <= 1'b1;
						stat_q[idx] <= mlfq_pkg::TS_READY;
						lvl_q[idx]  <= '0;
						time_q[idx] <= '0;
						if (!lval_q[0]) begin
							head_q[0] <= idx;
							lval_q[0] <= 1'b1;
						end
						tail_q[0] <= idx;
					end
				end
				mlfq_pkg::C_BLOCK: begin
					if (!id_ok || !used_q[idx])
						res_sts_q <= mlfq_pkg::STS_BAD;
					else
						stat_q[idx] <= mlfq_pkg::TS_BLOCKED;
				end
				mlfq_pkg::C_READY: begin
					if (!id_ok || !used_q[idx])
						res_sts_q <= mlfq_pkg::STS_BAD;
					else if (!(run_v_q && run_q == idx))
						stat_q[idx] <= mlfq_pkg::TS_READY;
				end
				mlfq_pkg::C_EXIT: begin
					if (run_v_q) begin
						used_q[run_q] <= 1'b0;
						stat_q[run_q] <= mlfq_pkg::TS_READY;
						lvl_q[run_q]  <= '0;
						time_q[run_q] <= '0;
						run_v_q       <= 1'b0;
					end
				end
				mlfq_pkg::C_CHARGE: begin
					stat_q[run_q] <= (rsn_q == mlfq_pkg::RSN_BLOCKED) ?
						mlfq_pkg::TS_BLOCKED : mlfq_pkg::TS_READY;
				end
				mlfq_pkg::C_DEMOTE: begin
					if (rl != LW'(NUM_LEVELS - 1) &&
						sat > 16'(mlfq_pkg::level_slice(base_q, step_q, 4'(rl)))) begin
						lvl_q[run_q]  <= rl + 1'b1;
						time_q[run_q] <= '0;
					end else begin
						time_q[run_q] <= sat;
					end
				end
				mlfq_pkg::C_PUSH: begin
					if (!lval_q[rl]) begin
						head_q[rl] <= run_q;
						lval_q[rl] <= 1'b1;
					end
					tail_q[rl] <= run_q;
					run_v_q    <= 1'b0;
				end
				mlfq_pkg::C_SCAN: begin
					if (used_q[scan_q] && stat_q[scan_q] != mlfq_pkg::TS_BLOCKED)
						flag_q[lvl_q[scan_q]] <= 1'b1;
					scan_q <= scan_q + 1'b1;
				end
				mlfq_pkg::C_SELECT: begin
					sel_q <= fnd;
					if (!any) begin
						res_sts_q <= mlfq_pkg::STS_NONE;
						run_v_q   <= 1'b0;
					end
				end
				mlfq_pkg::C_ROTATE: begin
					if (stat_q[hd] == mlfq_pkg::TS_BLOCKED) begin
						if (hd != tail_q[sel_q]) begin
							head_q[sel_q] <= link_q[hd];
							tail_q[sel_q] <= hd;
						end
					end else begin
						if (hd == tail_q[sel_q])
							lval_q[sel_q] <= 1'b0;
						else
							head_q[sel_q] <= link_q[hd];
						stat_q[hd] <= mlfq_pkg::TS_RUNNING;
						run_q      <= hd;
						run_v_q    <= 1'b1;
						res_sts_q  <= mlfq_pkg::STS_OK;
						res_nxt_q  <= hd8[3:0];
						res_slc_q  <= mlfq_pkg::level_slice(base_q, step_q, 4'(sel_q));
					end
				end
				mlfq_pkg::C_BOOST: begin
					// splice this level onto the tail of level 0
					if (lval_q[bl_q]) begin
						if (!lval_q[0]) begin
							head_q[0] <= head_q[bl_q];
							lval_q[0] <= 1'b1;
						end
						tail_q[0]     <= tail_q[bl_q];
						lval_q[bl_q]  <= 1'b0;
					end
					bl_q <= bl_q + 1'b1;
				end
				mlfq_pkg::C_BCLR: begin
					for (int i = 0; i < MAX_THREADS; i++) begin
						if (used_q[i]) begin
							lvl_q[i]  <= '0;
							time_q[i] <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== design/mlfq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlfq_ctrl
// Sequencer: steps the datapath through each scheduling request.
// ----------------------------------------------------------------------------
module mlfq_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [mlfq_pkg::OP_W-1:0] op,
	input  mlfq_pkg::sts_t            sts,
	output mlfq_pkg::ctl_t            ctl,
	output logic                      busy,
	output logic                      done
);
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CREATE = 4'd1;
	localparam logic [3:0] S_BLOCK  = 4'd2;
	localparam logic [3:0] S_READY  = 4'd3;
	localparam logic [3:0] S_EXIT   = 4'd4;
	localparam logic [3:0] S_CHARGE = 4'd5;
	localparam logic [3:0] S_DEMOTE = 4'd6;
	localparam logic [3:0] S_PUSH   = 4'd7;
	localparam logic [3:0] S_SCAN   = 4'd8;
	localparam logic [3:0] S_SELECT = 4'd9;
	localparam logic [3:0] S_ROTATE = 4'd10;
	localparam logic [3:0] S_BOOST  = 4'd11;
	localparam logic [3:0] S_BCLR   = 4'd12;
	localparam logic [3:0] S_DONE   = 4'd13;

	logic [3:0] state_q, nxt;

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;

	always_comb begin
		nxt     = state_q;
		ctl.cmd = mlfq_pkg::C_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.cmd = mlfq_pkg::C_LATCH;
					unique case (op)
						mlfq_pkg::OP_CREATE: nxt = S_CREATE;
						mlfq_pkg::OP_SWITCH: nxt = sts.run_v ? S_CHARGE : S_SCAN;
						mlfq_pkg::OP_EXIT:   nxt = S_EXIT;
						mlfq_pkg::OP_BLOCK:  nxt = S_BLOCK;
						mlfq_pkg::OP_READY:  nxt = S_READY;
						mlfq_pkg::OP_BOOST:  nxt = S_BOOST;
						default:             nxt = S_DONE;
					endcase
				end
			end
			S_CREATE: begin ctl.cmd = mlfq_pkg::C_CREATE; nxt = S_DONE; end
			S_BLOCK:  begin ctl.cmd = mlfq_pkg::C_BLOCK;  nxt = S_DONE; end
			S_READY:  begin ctl.cmd = mlfq_pkg::C_READY;  nxt = S_DONE; end
			S_EXIT:   begin ctl.cmd = mlfq_pkg::C_EXIT;   nxt = S_SCAN; end
			S_CHARGE: begin ctl.cmd = mlfq_pkg::C_CHARGE; nxt = S_DEMOTE; end
			S_DEMOTE: begin ctl.cmd = mlfq_pkg::C_DEMOTE; nxt = S_PUSH; end
			S_PUSH:   begin ctl.cmd = mlfq_pkg::C_PUSH;   nxt = S_SCAN; end
			S_SCAN: begin
				ctl.cmd = mlfq_pkg::C_SCAN;
				if (sts.scan_last)
					nxt = S_SELECT;
			end
			S_SELECT: begin
				ctl.cmd = mlfq_pkg::C_SELECT;
				nxt = sts.none_found ? S_DONE : S_ROTATE;
			end
			S_ROTATE: begin
				ctl.cmd = mlfq_pkg::C_ROTATE;
				if (!sts.head_blk)
					nxt = S_DONE;
			end
			S_BOOST: begin
				ctl.cmd = mlfq_pkg::C_BOOST;
				if (sts.boost_last)
					nxt = S_BCLR;
			end
			S_BCLR: begin ctl.cmd = mlfq_pkg::C_BCLR; nxt = S_DONE; end
			S_DONE: nxt = S_IDLE;
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= nxt;
	end

endmodule

// ===== design/mlfq_thread_scheduler.sv =====
// ----------------------------------------------------------------------------
// mlfq_thread_scheduler
// Multilevel feedback queue scheduler over a table of thread slots.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel: drive op, thread_id, elapsed_ms and leave_reason with
//    start high; the request is taken on an edge where busy is low.
//  - One result per request: status, next_thread and slice_ms are shown for
//    a single cycle with done high. The receiver cannot stall, so the result
//    must be captured in that cycle.
//  - Config channel: cfg_valid/cfg_ready with cfg_index (0 base slice,
//    1 slice step) and cfg_data. cfg_ready is always high; write only idle.
// Steps per request (request edge to done cycle):
//  - create, block, make ready: the op's own step, then done; unused ops: done.
//  - boost: one level spliced per cycle, then the level clear step and done.
//  - switch out / exit: charge, demote and requeue of the running thread
//    (exit frees it instead; a switch with nothing running skips these), then
//    the thread scan, one slot a cycle, then select, a rotate step per blocked
//    thread, a step to take the picked thread (none if nothing runs), and done.
// Reset: all slots free, every level empty, nothing running, slices 5/5 ms.
//  The link store holds no reset; a link is always written before it is read.
// ----------------------------------------------------------------------------
module mlfq_thread_scheduler #(
	parameter int MAX_THREADS = mlfq_pkg::MAX_THREADS_DEF,
	parameter int NUM_LEVELS  = mlfq_pkg::NUM_LEVELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [mlfq_pkg::OP_W-1:0]     op,
	input  logic [mlfq_pkg::ID_W-1:0]     thread_id,
	input  logic [mlfq_pkg::EL_W-1:0]     elapsed_ms,
	input  logic [mlfq_pkg::RSN_W-1:0]    leave_reason,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mlfq_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [mlfq_pkg::CFG_W-1:0]    cfg_data,
	output logic                          done,
	output logic [mlfq_pkg::STS_W-1:0]    status,
	output logic [mlfq_pkg::ID_W-1:0]     next_thread,
	output logic [mlfq_pkg::SLICE_W-1:0]  slice_ms
);
	mlfq_pkg::ctl_t ctl;
	mlfq_pkg::sts_t sts;

	// config is to be written only while idle (the block does not enforce it), so no back-pressure is needed
	assign cfg_ready = 1'b1;

	mlfq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	mlfq_dp #(
		.MAX_THREADS (MAX_THREADS),
		.NUM_LEVELS  (NUM_LEVELS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.thread_id    (thread_id),
		.elapsed_ms   (elapsed_ms),
		.leave_reason (leave_reason),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.status       (status),
		.next_thread  (next_thread),
		.slice_ms     (slice_ms)
	);

endmodule

// ===== design/mlfq_chk.sv =====
// ----------------------------------------------------------------------------
// mlfq_chk
// Port-level checks on the scheduler's request/result timing.
// ----------------------------------------------------------------------------
module mlfq_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [mlfq_pkg::STS_W-1:0]    status,
	input logic [mlfq_pkg::ID_W-1:0]     next_thread,
	input logic [mlfq_pkg::SLICE_W-1:0]  slice_ms
);
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request taken but not busy");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy ##1 !busy) else $error("done outside request");

	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held two cycles");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == mlfq_pkg::STS_NONE |-> next_thread == '0 && slice_ms == '0)
		else $error("nothing runnable with nonzero pick");
endmodule

bind mlfq_thread_scheduler mlfq_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.next_thread (next_thread),
	.slice_ms    (slice_ms)
);
